// File: rtl/ntt_tw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt twiddle generator package
// shared types and constants for the twiddle value generator
// ----------------------------------------------------------------------------
package ntt_tw_pkg;

   localparam int MAX_LOG_SIZE_DEF = 10;
   localparam int WORD_W           = 32;
   localparam int CSR_IDX_W        = 2;

   localparam logic [3:0]  LOG_SIZE_RST = 4'd7;
   localparam logic [31:0] MODULUS_RST  = 32'd11777;
   localparam logic [31:0] ROOT_RST     = 32'd5558;

   typedef enum logic [1:0] {
      CSR_LOG_SIZE = 2'd0,
      CSR_MODULUS  = 2'd1,
      CSR_ROOT     = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_FWD = 2'd0,
      OP_INV = 2'd1,
      OP_PLAIN_INV = 2'd2,
      OP_RSVD = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED,      // reduce operand mod q
      ST_EXP_MUL,  // issue a modular multiply
      ST_EXP_WAIT,
      ST_EUC_DIV,  // issue r0 / r1
      ST_EUC_WAIT,
      ST_EUC_T,    // t update: t0 - d * t1 mod q
      ST_EUC_TW,
      ST_DONE,
      ST_OUT
   } state_type;

   // reduction unit commands
   typedef enum logic [1:0] {
      MM_MUL,      // (a * b) mod q
      MM_DIV       // a / b and a mod b
   } mm_cmd_type;

endpackage

// File: rtl/ntt_tw_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt twiddle shared divider
// restoring divider, one quotient bit per cycle, 64 by 32 bits
// ----------------------------------------------------------------------------
module ntt_tw_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [31:0] remainder
);

   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      diff    = {1'b0, trial} - {2'b00, dvs_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[31:0];

endmodule

// File: rtl/ntt_twiddle_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt twiddle generator
// one twiddle value, inverse twiddle or modular inverse per request beat.
// every modular product and every euclid quotient goes through a single
// bit-serial divider, so each multiply costs a full divider pass: op 0 and
// op 1 cost up to 2*(w+1) multiplies for the saturated width w, op 1 and op 2
// add two divider passes per euclid round (tens of rounds for 32-bit q).
// the block takes one request at a time; the result sits in an output
// register and req_stall stays high until it has been taken
// ----------------------------------------------------------------------------
module ntt_twiddle_generator_top #(
   parameter int MAX_LOG_SIZE = ntt_tw_pkg::MAX_LOG_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [9:0]  req_index,
   input  logic [31:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic        rsp_not_invertible
);

   logic [3:0]  log_size_ff;
   logic [31:0] modulus_ff;
   logic [31:0] root_ff;

   ntt_tw_pkg::state_type state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [16:0] exp_ff, exp_in;        // remaining exponent bits
   logic        sq_ff, sq_in;           // next multiply is the squaring
   logic [31:0] acc_ff, acc_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] r0_ff, r0_in, r1_ff, r1_in;
   logic [31:0] t0_ff, t0_in, t1_ff, t1_in;   // coefficients kept mod q
   logic [31:0] d_ff, d_in;
   logic [31:0] val_ff, val_in;
   logic        flag_ff, flag_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        div_start;
   logic [63:0] div_dividend;
   logic [31:0] div_divisor;
   logic        div_done;
   logic [63:0] div_quo;
   logic [31:0] div_rem;

   logic [3:0]  w_sat;
   logic [15:0] k_rev;
   logic [16:0] e_full;
   logic [31:0] mul_a;
   logic [31:0] mul_b;
   logic [63:0] prod;
   logic [32:0] tsub;

   ntt_tw_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         log_size_ff <= ntt_tw_pkg::LOG_SIZE_RST;
         modulus_ff  <= ntt_tw_pkg::MODULUS_RST;
         root_ff     <= ntt_tw_pkg::ROOT_RST;
      end else if (csr_write) begin
         case (ntt_tw_pkg::csr_idx_type'(csr_index))
            ntt_tw_pkg::CSR_LOG_SIZE: log_size_ff <= csr_data[3:0];
            ntt_tw_pkg::CSR_MODULUS:  modulus_ff  <= csr_data;
            ntt_tw_pkg::CSR_ROOT:     root_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // bit reversal over the saturated width
   always_comb begin
      if (log_size_ff == 4'd0) begin
         w_sat = 4'd1;
      end else if (32'(log_size_ff) > MAX_LOG_SIZE) begin
         w_sat = 4'(MAX_LOG_SIZE);
      end else begin
         w_sat = log_size_ff;
      end
      k_rev = '0;
      for (int i = 0; i < 16; i++) begin
         if (i < 32'(w_sat) && i < 10) begin
            k_rev[32'(w_sat) - 1 - i] = req_index[i];
         end
      end
      e_full = {1'b0, k_rev} + ((req_op == ntt_tw_pkg::OP_INV) ? 17'd1 : 17'd0);
   end

   // one multiplier, shared by the exponent steps and the euclid t update
   always_comb begin
      if (state_ff == ntt_tw_pkg::ST_EUC_T) begin
         mul_a = d_ff;
         mul_b = t1_ff;
      end else begin
         mul_a = sq_ff ? base_ff : acc_ff;
         mul_b = base_ff;
      end
      prod = 64'(mul_a) * 64'(mul_b);
      tsub = {1'b0, t0_ff} - {1'b0, div_rem};
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      exp_in       = exp_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      base_in      = base_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      d_in         = d_ff;
      val_in       = val_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = modulus_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ntt_tw_pkg::ST_IDLE: begin
            if (req_valid && !rsp_valid_ff) begin
               op_in  = req_op;
               exp_in = e_full;
               acc_in = (modulus_ff == 32'd1) ? 32'd0 : 32'd1;
               sq_in  = 1'b0;
               if (req_op == ntt_tw_pkg::OP_RSVD) begin
                  val_in = '0; flag_in = 1'b0; state_in = ntt_tw_pkg::ST_OUT;
               end else if (modulus_ff < 32'd2) begin
                  val_in  = '0;
                  flag_in = (req_op != ntt_tw_pkg::OP_FWD);
                  state_in = ntt_tw_pkg::ST_OUT;
               end else begin
                  div_start    = 1'b1;
                  div_dividend = (req_op == ntt_tw_pkg::OP_PLAIN_INV) ?
                                 64'(req_operand) : 64'(root_ff);
                  state_in = ntt_tw_pkg::ST_RED;
               end
            end
         end
         ntt_tw_pkg::ST_RED: begin
            if (div_done) begin
               if (op_ff == ntt_tw_pkg::OP_PLAIN_INV) begin
                  r1_in = div_rem;
                  r0_in = modulus_ff;
                  t0_in = '0;
                  t1_in = 32'd1;
                  state_in = ntt_tw_pkg::ST_EUC_DIV;
               end else begin
                  base_in  = div_rem;
                  state_in = ntt_tw_pkg::ST_EXP_MUL;
               end
            end
         end
         ntt_tw_pkg::ST_EXP_MUL: begin
            if (exp_ff == '0) begin
               if (op_ff == ntt_tw_pkg::OP_FWD) begin
                  val_in = acc_ff; flag_in = 1'b0; state_in = ntt_tw_pkg::ST_OUT;
               end else begin
                  r0_in = modulus_ff; r1_in = acc_ff;
                  t0_in = '0; t1_in = 32'd1;
                  state_in = ntt_tw_pkg::ST_EUC_DIV;
               end
            end else if (!sq_ff && !exp_ff[0]) begin
               sq_in = 1'b1;
            end else begin
               div_start    = 1'b1;
               div_dividend = prod;
               state_in     = ntt_tw_pkg::ST_EXP_WAIT;
            end
         end
         ntt_tw_pkg::ST_EXP_WAIT: begin
            if (div_done) begin
               if (sq_ff) begin
                  base_in = div_rem;
                  sq_in   = 1'b0;
                  exp_in  = exp_ff >> 1;
               end else begin
                  acc_in = div_rem;
                  sq_in  = 1'b1;
               end
               state_in = ntt_tw_pkg::ST_EXP_MUL;
            end
         end
         ntt_tw_pkg::ST_EUC_DIV: begin
            if (r1_ff == '0) begin
               state_in = ntt_tw_pkg::ST_DONE;
            end else begin
               div_start    = 1'b1;
               div_dividend = 64'(r0_ff);
               div_divisor  = r1_ff;
               state_in     = ntt_tw_pkg::ST_EUC_WAIT;
            end
         end
         ntt_tw_pkg::ST_EUC_WAIT: begin
            if (div_done) begin
               d_in  = div_quo[31:0];
               r0_in = r1_ff;
               r1_in = div_rem;
               state_in = ntt_tw_pkg::ST_EUC_T;
            end
         end
         ntt_tw_pkg::ST_EUC_T: begin
            // (d * t1) mod q, then t0 - that mod q
            div_start    = 1'b1;
            div_dividend = prod;
            state_in     = ntt_tw_pkg::ST_EUC_TW;
         end
         ntt_tw_pkg::ST_EUC_TW: begin
            if (div_done) begin
               t0_in = t1_ff;
               t1_in = tsub[32] ? (tsub[31:0] + modulus_ff) : tsub[31:0];
               state_in = ntt_tw_pkg::ST_EUC_DIV;
            end
         end
         ntt_tw_pkg::ST_DONE: begin
            if (r0_ff == 32'd1) begin
               val_in = t0_ff; flag_in = 1'b0;
            end else begin
               val_in = '0; flag_in = 1'b1;
            end
            state_in = ntt_tw_pkg::ST_OUT;
         end
         ntt_tw_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = ntt_tw_pkg::ST_IDLE;
         end
         default: state_in = ntt_tw_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntt_tw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff   <= op_in;
      exp_ff  <= exp_in;
      sq_ff   <= sq_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      r0_ff   <= r0_in;
      r1_ff   <= r1_in;
      t0_ff   <= t0_in;
      t1_ff   <= t1_in;
      d_ff    <= d_in;
      val_ff  <= val_in;
      flag_ff <= flag_in;
   end

   assign req_stall          = (state_ff != ntt_tw_pkg::ST_IDLE) || rsp_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = val_ff;
   assign rsp_not_invertible = flag_ff;

   // a flagged result always carries zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && flag_ff |-> val_ff == '0)
      else $error("flagged result with non-zero value");

   // an unflagged result is reduced below the modulus
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !flag_ff && modulus_ff >= 32'd2 |-> val_ff < modulus_ff)
      else $error("result not reduced");

   // accepting a request always leaves idle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != ntt_tw_pkg::ST_IDLE)
      else $error("request accepted but sequencer stayed idle");

   // the response register is only loaded from the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ntt_tw_pkg::ST_OUT)
      else $error("response raised outside output state");

endmodule
